/* design/mbsd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbsd_pkg
// Shared types and constants for the multi-button shift debouncer.
// ----------------------------------------------------------------------------
package mbsd_pkg;

    localparam int BUTTON_TOTAL = 4;
    localparam int IDX_W        = (BUTTON_TOTAL > 1) ? $clog2(BUTTON_TOTAL) : 1;
    localparam int HIST_W       = 8;

    localparam logic [HIST_W-1:0] HISTORY_RESET = 8'h55;
    localparam logic [HIST_W-1:0] MASK_RESET    = 8'h0F;

    // stream layout
    localparam int IN_DATA_W  = 8;   // pin_levels[3:0], button_index[5:4]
    localparam int IN_USER_W  = 2;   // action
    localparam int OUT_DATA_W = 8;   // down_flags[3:0], event_seen[4]

    // config port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_MASK_IDX = 1'b0;

    typedef enum logic [1:0] {
        ACT_TICK          = 2'd0,
        ACT_TAKE_PRESSED  = 2'd1,
        ACT_TAKE_RELEASED = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_UP      = 2'd0,
        ST_DOWN    = 2'd1,
        ST_UNKNOWN = 2'd3
    } t_status;

endpackage

/* design/multi_button_shift_debouncer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_button_shift_debouncer_core
// Shift-register debouncer for several active-low buttons with sticky
// pressed/released events and an APB register for the agreement mask.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake                  Payload
// s_axis    in   i_s_axis_tvalid/o_tready   tdata: pins, index; tuser: action
// m_axis    out  o_m_axis_tvalid/i_tready   tdata: down flags, event seen
// apb       in   psel/penable/pready        active_window_mask at 0x0
//
// One item per cycle while the result register is empty or being drained;
// each item is registered straight into the result register. State updates at the edge an item is accepted.
// Synchronous active-low reset; history 0x55, status unknown, mask 0x0F.
// Input is taken while the result register is empty or being drained.
// ----------------------------------------------------------------------------
module multi_button_shift_debouncer_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // stream in
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [mbsd_pkg::IN_DATA_W-1:0]  i_s_axis_tdata, // [3:0] pin_levels, [5:4] button_index
    input  logic [mbsd_pkg::IN_USER_W-1:0]  i_s_axis_tuser, // [1:0] action
    // stream out
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [mbsd_pkg::OUT_DATA_W-1:0] o_m_axis_tdata, // [3:0] down_flags, [4] event_seen
    // config
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mbsd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mbsd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mbsd_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready
);
    import mbsd_pkg::*;

    logic [HIST_W-1:0]       r_mask;
    logic [HIST_W-1:0]       r_hist [BUTTON_TOTAL];
    t_status                 r_status [BUTTON_TOTAL];
    logic [BUTTON_TOTAL-1:0] r_pressed_pend;
    logic [BUTTON_TOTAL-1:0] r_released_pend;
    logic                    r_out_valid;
    logic [OUT_DATA_W-1:0]   r_out_data;

    logic [HIST_W-1:0]       n_hist [BUTTON_TOTAL];
    t_status                 n_status [BUTTON_TOTAL];
    logic [BUTTON_TOTAL-1:0] n_pressed_pend;
    logic [BUTTON_TOTAL-1:0] n_released_pend;
    logic [BUTTON_TOTAL-1:0] n_down;
    logic                    n_seen;

    logic                    w_in_fire;
    logic                    w_cfg_wr;
    logic [BUTTON_TOTAL-1:0] w_pins;
    logic [IDX_W-1:0]        w_idx;
    t_action                 w_action;
    logic [HIST_W-1:0]       w_sel [BUTTON_TOTAL];
    logic [BUTTON_TOTAL-1:0] w_cur_down;
    logic [BUTTON_TOTAL-1:0] w_cur_up;

    assign pready          = 1'b1;
    assign w_cfg_wr        = psel & penable & pwrite & pready;
    assign prdata          = (paddr[2] == REG_MASK_IDX)
                             ? {{(APB_DATA_W-HIST_W){1'b0}}, r_mask} : '0;

    assign o_s_axis_tready = ~r_out_valid | i_m_axis_tready;
    assign w_in_fire       = i_s_axis_tvalid & o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    assign w_pins   = i_s_axis_tdata[BUTTON_TOTAL-1:0];
    assign w_idx    = i_s_axis_tdata[4 +: IDX_W];
    assign w_action = t_action'(i_s_axis_tuser);

    always_comb begin
        for (int i = 0; i < BUTTON_TOTAL; i++) begin
            n_hist[i]   = r_hist[i];
            n_status[i] = r_status[i];
            w_sel[i]    = '0;
        end
        n_pressed_pend  = r_pressed_pend;
        n_released_pend = r_released_pend;
        n_seen          = 1'b0;
        case (w_action)
            ACT_TICK: begin
                for (int i = 0; i < BUTTON_TOTAL; i++) begin
                    n_hist[i] = {r_hist[i][HIST_W-2:0], ~w_pins[i]};
                    w_sel[i]  = n_hist[i] & r_mask;
                    if (w_sel[i] == r_mask) begin
                        if (r_status[i] == ST_UP) n_pressed_pend[i] = 1'b1;
                        n_status[i] = ST_DOWN;
                    end else if (w_sel[i] == '0) begin
                        if (r_status[i] == ST_DOWN) n_released_pend[i] = 1'b1;
                        n_status[i] = ST_UP;
                    end
                end
            end
            ACT_TAKE_PRESSED: begin
                n_seen                = r_pressed_pend[w_idx];
                n_pressed_pend[w_idx] = 1'b0;
            end
            ACT_TAKE_RELEASED: begin
                n_seen                 = r_released_pend[w_idx];
                n_released_pend[w_idx] = 1'b0;
            end
            default: begin
            end
        endcase
        for (int i = 0; i < BUTTON_TOTAL; i++) begin
            n_down[i]     = (n_status[i] == ST_DOWN);
            w_cur_down[i] = (r_status[i] == ST_DOWN);
            w_cur_up[i]   = (r_status[i] == ST_UP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask          <= MASK_RESET;
            r_pressed_pend  <= '0;
            r_released_pend <= '0;
            r_out_valid     <= 1'b0;
            for (int i = 0; i < BUTTON_TOTAL; i++) begin
                r_hist[i]   <= HISTORY_RESET;
                r_status[i] <= ST_UNKNOWN;
            end
        end else begin
            if (w_cfg_wr && paddr[2] == REG_MASK_IDX) begin
                r_mask <= pwdata[HIST_W-1:0];
            end
            if (w_in_fire) begin
                r_pressed_pend  <= n_pressed_pend;
                r_released_pend <= n_released_pend;
                for (int i = 0; i < BUTTON_TOTAL; i++) begin
                    r_hist[i]   <= n_hist[i];
                    r_status[i] <= n_status[i];
                end
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_out_data <= {{(OUT_DATA_W-BUTTON_TOTAL-1){1'b0}}, n_seen, n_down};
        end
    end

    // a new pressed event only appears on a button that just went down
    a_pressed_on_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_pressed_pend & ~$past(r_pressed_pend)) & ~w_cur_down) == '0)
        else $error("pressed event latched without down status");

    // a new released event only appears on a button that just went up
    a_released_on_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_released_pend & ~$past(r_released_pend)) & ~w_cur_up) == '0)
        else $error("released event latched without up status");

    // a tick never reports an event
    a_tick_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && w_action == ACT_TICK) |=> (r_out_data[BUTTON_TOTAL] == 1'b0))
        else $error("event_seen set on a tick");

endmodule
